/* rtl/core/matrix_keypad_press_hold_tracker_assert.svh */
// Assertion macros used by the keypad tracker state machine (kpht_fsm).
`ifndef MATRIX_KEYPAD_PRESS_HOLD_TRACKER_ASSERT_SVH
`define MATRIX_KEYPAD_PRESS_HOLD_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS

`define KPHT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("keypad tracker assertion failed");

`define KPHT_ASSERT_STEP(lbl, clk, rst_n, trig, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("keypad tracker step assertion failed");

`else

`define KPHT_ASSERT(lbl, clk, rst_n, prop)

`define KPHT_ASSERT_STEP(lbl, clk, rst_n, trig, prop)

`endif

`endif

/* rtl/core/kpht_pkg.sv */
package kpht_pkg;

    localparam int MATRIX_W   = 16;
    localparam int ROW_STRIDE = 4;
    localparam int ROW_MAX    = 4;
    localparam int COL_MAX    = 4;
    localparam int POS_W      = 4;
    localparam int KEY_W      = 8;
    localparam int KEYMAP_W   = 64;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int HOLD_W     = 16;
    localparam int TICK_W     = 13;

    localparam logic [TICK_W-1:0] TICKS_MAX    = 13'd8191;
    localparam logic [TICK_W-1:0] HOLD_DEFAULT = 13'd50;

    // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
    localparam int               HOLD_PROD_W = 33;
    localparam logic [16:0]      HOLD_RECIP  = 17'd52429;
    localparam int               HOLD_SHIFT  = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_PRESSED  = 2'd1,
        ST_HOLD     = 2'd2,
        ST_RELEASED = 2'd3
    } t_key_state;

    typedef struct packed {
        logic [KEY_W-1:0] new_key;
        t_key_state       key_state;
        logic [KEY_W-1:0] held_key;
        logic [KEY_W-1:0] released_key;
    } t_result;

endpackage

/* rtl/core/kpht_scan.sv */
module kpht_scan #(
    parameter int ROW_COUNT = 4,
    parameter int COL_COUNT = 4
) (
    input  logic [kpht_pkg::MATRIX_W-1:0]   i_matrix,
    input  logic [kpht_pkg::KEYMAP_W-1:0]   i_keymap_low,
    input  logic [kpht_pkg::KEYMAP_W-1:0]   i_keymap_high,
    output logic [kpht_pkg::KEY_W-1:0]      o_key
);

    logic [kpht_pkg::MATRIX_W-1:0]     w_enable;
    logic [kpht_pkg::MATRIX_W-1:0]     w_masked;
    logic [2*kpht_pkg::KEYMAP_W-1:0]   w_keymap;
    logic [kpht_pkg::POS_W-1:0]        w_pos;
    logic                              w_hit;

    for (genvar r = 0; r < kpht_pkg::ROW_MAX; r++) begin : g_row
        for (genvar c = 0; c < kpht_pkg::COL_MAX; c++) begin : g_col
            assign w_enable[r*kpht_pkg::ROW_STRIDE + c] = (r < ROW_COUNT) && (c < COL_COUNT);
        end
    end

    assign w_masked = i_matrix & w_enable;
    assign w_keymap = {i_keymap_high, i_keymap_low};

    // lowest set position wins
    always_comb begin
        w_hit = 1'b0;
        w_pos = '0;
        for (int p = kpht_pkg::MATRIX_W - 1; p >= 0; p--) begin
            if (w_masked[p]) begin
                w_hit = 1'b1;
                w_pos = kpht_pkg::POS_W'(p);
            end
        end
    end

    assign o_key = w_hit ? w_keymap[w_pos*kpht_pkg::KEY_W +: kpht_pkg::KEY_W] : '0;

endmodule

/* rtl/core/kpht_fsm.sv */
`include "matrix_keypad_press_hold_tracker_assert.svh"

module kpht_fsm (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [kpht_pkg::KEY_W-1:0]      i_key,
    input  logic [kpht_pkg::TICK_W-1:0]     i_hold_ticks,
    output kpht_pkg::t_result               o_result
);

    kpht_pkg::t_key_state             r_state,    n_state;
    logic [kpht_pkg::KEY_W-1:0]       r_tracked,  n_tracked;
    logic [kpht_pkg::KEY_W-1:0]       r_released, n_released;
    logic [kpht_pkg::TICK_W-1:0]      r_ticks,    n_ticks;
    logic [kpht_pkg::KEY_W-1:0]       w_new_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= kpht_pkg::ST_IDLE;
            r_tracked  <= '0;
            r_released <= '0;
            r_ticks    <= '0;
        end else if (i_step) begin
            r_state    <= n_state;
            r_tracked  <= n_tracked;
            r_released <= n_released;
            r_ticks    <= n_ticks;
        end
    end

    always_comb begin
        if (r_state == kpht_pkg::ST_IDLE && i_key != '0) begin
            n_ticks = '0;
        end else if (r_ticks < kpht_pkg::TICKS_MAX) begin
            n_ticks = r_ticks + 1'b1;
        end else begin
            n_ticks = r_ticks;
        end

        n_state = r_state;
        case (r_state)
            kpht_pkg::ST_IDLE: begin
                if (i_key != '0) begin
                    n_state = kpht_pkg::ST_PRESSED;
                end
            end
            kpht_pkg::ST_PRESSED: begin
                if (i_key == r_tracked) begin
                    if (n_ticks >= i_hold_ticks) begin
                        n_state = kpht_pkg::ST_HOLD;
                    end
                end else if (i_key == '0) begin
                    n_state = kpht_pkg::ST_RELEASED;
                end
            end
            kpht_pkg::ST_HOLD: begin
                if (i_key != r_tracked) begin
                    n_state = kpht_pkg::ST_RELEASED;
                end
            end
            default: begin
                n_state = kpht_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_tracked  = r_tracked;
        n_released = r_released;
        w_new_key  = '0;
        case (r_state)
            kpht_pkg::ST_IDLE: begin
                if (i_key != '0) begin
                    n_tracked = i_key;
                    w_new_key = i_key;
                end
            end
            kpht_pkg::ST_PRESSED: begin
                if (i_key != r_tracked && i_key == '0) begin
                    n_released = r_tracked;
                end
            end
            kpht_pkg::ST_HOLD: begin
                if (i_key != r_tracked) begin
                    n_released = r_tracked;
                end
            end
            default: begin
                n_tracked = '0;
            end
        endcase
    end

    assign o_result.new_key      = w_new_key;
    assign o_result.key_state    = n_state;
    assign o_result.held_key     = n_tracked;
    assign o_result.released_key = n_released;

    `KPHT_ASSERT(a_tracked_when_down, i_clk, i_rst_n,
        (r_state == kpht_pkg::ST_PRESSED || r_state == kpht_pkg::ST_HOLD) |-> r_tracked != '0)
    `KPHT_ASSERT_STEP(a_idle_exit, i_clk, i_rst_n, i_step && r_state == kpht_pkg::ST_IDLE,
        r_state == kpht_pkg::ST_IDLE || r_state == kpht_pkg::ST_PRESSED)
    `KPHT_ASSERT_STEP(a_release_clears, i_clk, i_rst_n, i_step && r_state == kpht_pkg::ST_RELEASED,
        r_state == kpht_pkg::ST_IDLE && r_tracked == '0)
    `KPHT_ASSERT_STEP(a_hold_without_step, i_clk, i_rst_n, !i_step,
        $stable(r_state) && $stable(r_ticks) && $stable(r_released))

endmodule

/* rtl/core/matrix_keypad_press_hold_tracker.sv */
// Keypad press/hold tracker.
// Input channel (i_in_valid / o_in_ready) takes one scan request per tick: a
// 16-bit snapshot of the key matrix, bit row*4+col high for a closed key.
// The first closed key in row-major order is translated through the keymap
// registers, and a four-state machine (idle, pressed, hold, released) is
// advanced once per request.
// Output channel (o_out_valid / i_out_ready) returns one result per request:
// the new key on an idle-to-pressed step, the state, the tracked key, the
// last released key and a key-down flag.
// From accept to result valid, the input register takes the request, then
// the scan, keymap select and state update load the result register.
// Throughput is one request per cycle while the receiver takes results.
// When the receiver stalls, one result waits in the result register and one
// more request is still taken into the input register; after that o_in_ready
// drops until the result is taken.
// Configuration writes take effect at the write edge; the hold threshold is
// hold_time_ms / 10, computed once when that register is written.
// Reset clears the state machine, the pipeline and the keymap, and sets the
// hold time to 500.
module matrix_keypad_press_hold_tracker #(
    parameter int ROW_COUNT = 4,
    parameter int COL_COUNT = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [kpht_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kpht_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [kpht_pkg::MATRIX_W-1:0]      i_key_matrix,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [kpht_pkg::KEY_W-1:0]         o_new_key,
    output logic [1:0]                         o_key_state,
    output logic [kpht_pkg::KEY_W-1:0]         o_held_key,
    output logic [kpht_pkg::KEY_W-1:0]         o_released_key,
    output logic                               o_key_down
);

    logic [kpht_pkg::KEYMAP_W-1:0]     r_keymap_low;
    logic [kpht_pkg::KEYMAP_W-1:0]     r_keymap_high;
    logic [kpht_pkg::TICK_W-1:0]       r_hold_ticks;
    logic [kpht_pkg::HOLD_PROD_W-1:0]  w_hold_prod;

    logic                              r_in_valid;
    logic [kpht_pkg::MATRIX_W-1:0]     r_in_matrix;
    logic                              r_out_valid;
    kpht_pkg::t_result                 r_out;

    logic                              w_advance;
    logic [kpht_pkg::KEY_W-1:0]        w_key;
    kpht_pkg::t_result                 w_result;

    assign w_hold_prod = kpht_pkg::HOLD_PROD_W'(i_cfg_data[kpht_pkg::HOLD_W-1:0])
                       * kpht_pkg::HOLD_PROD_W'(kpht_pkg::HOLD_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keymap_low  <= '0;
            r_keymap_high <= '0;
            r_hold_ticks  <= kpht_pkg::HOLD_DEFAULT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kpht_pkg::CFG_KEYMAP_LOW:  r_keymap_low  <= i_cfg_data;
                kpht_pkg::CFG_KEYMAP_HIGH: r_keymap_high <= i_cfg_data;
                kpht_pkg::CFG_HOLD_TIME: begin
                    r_hold_ticks <= w_hold_prod[kpht_pkg::HOLD_SHIFT +: kpht_pkg::TICK_W];
                end
                default: ;
            endcase
        end
    end

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_matrix <= i_key_matrix;
        end
    end

    kpht_scan #(
        .ROW_COUNT (ROW_COUNT),
        .COL_COUNT (COL_COUNT)
    ) u_scan (
        .i_matrix      (r_in_matrix),
        .i_keymap_low  (r_keymap_low),
        .i_keymap_high (r_keymap_high),
        .o_key         (w_key)
    );

    kpht_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_advance),
        .i_key        (w_key),
        .i_hold_ticks (r_hold_ticks),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_new_key      = r_out.new_key;
    assign o_key_state    = r_out.key_state;
    assign o_held_key     = r_out.held_key;
    assign o_released_key = r_out.released_key;
    assign o_key_down     = (r_out.key_state == kpht_pkg::ST_PRESSED)
                         || (r_out.key_state == kpht_pkg::ST_HOLD);

endmodule
